FILE: src/chbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body framer package
// Phase codes, byte kind codes, character constants and the hex digit decoder
// shared by the chunked body framer.
// ----------------------------------------------------------------------------
package chbf_pkg;

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_PAIR = 2'd2
    } phase_t;

    localparam logic [1:0] KIND_SIZE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_PAIR = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam int CHUNK_SIZE_W = 32;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.hit   = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.hit   = 1'b1;
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.hit   = 1'b1;
            d.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.hit   = 1'b1;
            d.value = 4'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

FILE: src/http_chunked_body_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP chunked body framer
// Tags each byte of a chunked message body as size-line, chunk data or
// trailing pair byte, and reports the parsed chunk size at the end of each
// size line.
// ----------------------------------------------------------------------------
// The block takes one byte in every clock cycle while the downstream side is
// ready and delivers its tagged copy in the next cycle from a single output
// register; the whole per-byte parse (hex accumulation, byte counting, phase
// update) is done in the cycle in which the byte is accepted, so sustained
// throughput is one byte per cycle whenever the downstream side is ready.
module http_chunked_body_framer_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] byte_out, [39:8] chunk_size
    output logic [3:0]  m_axis_tuser,   // [1:0] byte_kind, [2] size_valid,
                                        // [3] size_overflow
    output logic        m_axis_tlast    // body_end
);
    import chbf_pkg::*;

    localparam int CNT_W = SIZE_BITS + 1;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] hex_accum_reg, hex_accum_next;
    logic                 seen_digit_reg, seen_digit_next;
    logic                 digits_closed_reg, digits_closed_next;
    logic                 prev_was_cr_reg, prev_was_cr_next;
    logic [CNT_W-1:0]     bytes_left_reg, bytes_left_next;
    logic                 overflow_seen_reg, overflow_seen_next;
    logic                 final_chunk_reg, final_chunk_next;

    logic                 out_valid_reg;
    logic [39:0]          out_data_reg, out_data_next;
    logic [3:0]           out_user_reg, out_user_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_fire;
    logic                 data_mode;
    logic [CNT_W-1:0]     bytes_dec;
    logic [CNT_W-1:0]     size_plus2;
    logic                 size_zero;
    logic [63:0]          accum_wide;
    hex_digit_t           digit;
    logic                 accum_sat;
    logic [7:0]           c;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign c          = s_axis_tdata;
    assign data_mode  = (phase_reg == PH_DATA || phase_reg == PH_PAIR) &&
                        (bytes_left_reg != '0);
    assign bytes_dec  = bytes_left_reg - CNT_W'(1);
    assign size_plus2 = {1'b0, hex_accum_reg} + CNT_W'(2);
    assign size_zero  = (hex_accum_reg == '0);
    assign accum_wide = 64'(hex_accum_reg);
    assign digit      = hex_decode(c);
    assign accum_sat  = |hex_accum_reg[SIZE_BITS-1 -: 4];

    always_comb
    begin
        phase_next         = phase_reg;
        hex_accum_next     = hex_accum_reg;
        seen_digit_next    = seen_digit_reg;
        digits_closed_next = digits_closed_reg;
        prev_was_cr_next   = prev_was_cr_reg;
        bytes_left_next    = bytes_left_reg;
        overflow_seen_next = overflow_seen_reg;
        final_chunk_next   = final_chunk_reg;
        out_data_next      = {32'd0, c};
        out_user_next      = {2'b00, KIND_SIZE};
        out_last_next      = 1'b0;

        if (data_mode)
        begin
            out_user_next[1:0] = (bytes_left_reg > CNT_W'(2)) ? KIND_DATA : KIND_PAIR;
            bytes_left_next    = bytes_dec;
            prev_was_cr_next   = (c == CH_CR);
            if (bytes_dec == '0)
            begin
                phase_next = PH_SIZE;
                if (final_chunk_reg)
                begin
                    out_last_next    = 1'b1;
                    final_chunk_next = 1'b0;
                    prev_was_cr_next = 1'b0;
                end
            end
            else
            begin
                phase_next = (bytes_dec > CNT_W'(2)) ? PH_DATA : PH_PAIR;
            end
        end
        else
        begin
            phase_next = PH_SIZE;
            if (c == CH_LF && prev_was_cr_reg)
            begin
                out_user_next[2]    = 1'b1;
                out_user_next[3]    = overflow_seen_reg;
                out_data_next[39:8] = accum_wide[CHUNK_SIZE_W-1:0];
                bytes_left_next     = size_plus2;
                final_chunk_next    = size_zero;
                phase_next          = size_zero ? PH_PAIR : PH_DATA;
                hex_accum_next      = '0;
                seen_digit_next     = 1'b0;
                digits_closed_next  = 1'b0;
                overflow_seen_next  = 1'b0;
            end
            else if (!digits_closed_reg)
            begin
                if (digit.hit)
                begin
                    seen_digit_next = 1'b1;
                    if (accum_sat)
                    begin
                        hex_accum_next     = '1;
                        overflow_seen_next = 1'b1;
                    end
                    else
                    begin
                        hex_accum_next = {hex_accum_reg[SIZE_BITS-5:0], digit.value};
                    end
                end
                else if (!seen_digit_reg && (c == CH_SPACE || c == CH_TAB))
                begin
                    hex_accum_next = hex_accum_reg;
                end
                else
                begin
                    digits_closed_next = 1'b1;
                end
            end
            prev_was_cr_next = (c == CH_CR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SIZE;
            hex_accum_reg     <= '0;
            seen_digit_reg    <= 1'b0;
            digits_closed_reg <= 1'b0;
            prev_was_cr_reg   <= 1'b0;
            bytes_left_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            final_chunk_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg         <= phase_next;
                hex_accum_reg     <= hex_accum_next;
                seen_digit_reg    <= seen_digit_next;
                digits_closed_reg <= digits_closed_next;
                prev_was_cr_reg   <= prev_was_cr_next;
                bytes_left_reg    <= bytes_left_next;
                overflow_seen_reg <= overflow_seen_next;
                final_chunk_reg   <= final_chunk_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // A size line result is always tagged as a size-line byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == KIND_SIZE)
        else $error("size line end not tagged as size-line byte");

    // The end of the body falls on a trailing pair byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == KIND_PAIR)
        else $error("body end outside the trailing pair");

    // The data phase always has more than the trailing pair left to count.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg > CNT_W'(2))
        else $error("data phase with too few bytes left");

    // The trailing pair phase has one or two bytes left.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAIR |-> bytes_left_reg != '0 && bytes_left_reg <= CNT_W'(2))
        else $error("pair phase with a bad byte count");

    // Every accepted byte shows up at the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_axis_tvalid)
        else $error("accepted byte lost");

endmodule
